// ===== hdl/aps_pkg.sv =====
package aps_pkg;

  // table geometry
  localparam int MAX_INSTANCES = 64;
  localparam int SLOT_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int CNT_W  = $clog2(MAX_INSTANCES + 1);

  localparam logic [15:0] CD_IDLE = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_START   = 3'd1,
    MODE_PAUSE   = 3'd2,
    MODE_UNPAUSE = 3'd3,
    MODE_DEACT   = 3'd4,
    MODE_TICK    = 3'd5,
    MODE_QUERY   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_QRY,
    S_DATA
  } state_t;

  // one slot of the instance table
  typedef struct packed {
    logic [15:0] cd;
    logic [14:0] period;
    logic [7:0]  poses;
    logic [7:0]  cur;
    logic [16:0] root;
    logic [19:0] xf;
    logic [7:0]  meshes;
    logic        has_pose;
  } rec_t;

  // what the update unit is asked to do with the slot just read
  typedef struct packed {
    logic        walk;
    mode_t       mode;
    logic [14:0] frame_period;
    logic [7:0]  pose_count;
    logic [15:0] pose_base;
    logic [15:0] transform_base;
    logic [7:0]  mesh_count;
  } upd_req_t;

endpackage

// ===== hdl/animation_pose_stepper_core.sv =====
// Channel  Direction  Ports                                       Word taken when
// input    in         in_mode .. in_mesh_count, in_valid/ready    in_valid && in_ready
// result   out        out_paused .. out_transform_index, v/r      out_valid && out_ready
// config   in         cfg_we, cfg_wdata (instance_count)          cfg_we
//
// Steps: clear, start, pause, unpause, deactivate and query each go through
// accept, table read and update/result. A tick walks n slots, n being
// instance_count capped at MAX_INSTANCES: the walk streams one slot a cycle
// through the single read port of the slot table, read and write-back
// overlapping on neighbouring slots, then drains before the query and result.
// Reset: synchronous, active low; clears the valid bits of the table, so no
// clearing pass is needed.
// Stalls: a new word is taken while a result waits; the block then holds in
// its result step until the output register frees.
module animation_pose_stepper_core
  import aps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [5:0]  in_instance_req,
  input  logic [14:0] in_frame_period,
  input  logic [7:0]  in_pose_count,
  input  logic [15:0] in_pose_base,
  input  logic [15:0] in_transform_base,
  input  logic [7:0]  in_mesh_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_paused,
  output logic        out_deactivated,
  output logic [7:0]  out_pose_id,
  output logic [16:0] out_pose_index,
  output logic [19:0] out_transform_index,
  // configuration
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [6:0] instance_count_r;

  // latched word
  mode_t       mode_r;
  logic [5:0]  req_r;
  logic [14:0] period_r;
  logic [7:0]  pc_r;
  logic [15:0] pb_r;
  logic [15:0] tb_r;
  logic [7:0]  mc_r;

  // walk pipeline: index to issue, and the slot whose data is back
  logic [CNT_W-1:0]  walk_idx_r;
  logic              rv_r;
  logic [SLOT_W-1:0] ra_r;
  logic [CNT_W-1:0]  n_lim;

  logic        out_valid_r;
  logic        out_paused_r;
  logic        out_deact_r;
  logic [7:0]  out_pose_id_r;
  logic [16:0] out_pose_index_r;
  logic [19:0] out_xf_r;

  logic              accept;
  logic              slot_ok;
  logic [SLOT_W-1:0] req_addr;
  logic              out_free;
  logic              issue;
  logic              walk_done;
  logic              wr_mode;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic              clr_all;
  logic              out_load;

  rec_t     rd_rec;
  rec_t     upd_rec;
  upd_req_t upd_req;

  assign accept    = in_valid && in_ready;
  assign slot_ok   = 32'(req_r) < MAX_INSTANCES;
  assign req_addr  = SLOT_W'(req_r);
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_WALK) && (walk_idx_r < n_lim);
  assign walk_done = (walk_idx_r >= n_lim) && !rv_r;
  assign wr_mode   = (mode_r == MODE_START) || (mode_r == MODE_PAUSE) ||
                     (mode_r == MODE_UNPAUSE) || (mode_r == MODE_DEACT);

  // tick walks at most the table depth
  always_comb begin
    if (32'(instance_count_r) > MAX_INSTANCES) begin
      n_lim = CNT_W'(MAX_INSTANCES);
    end else begin
      n_lim = CNT_W'(instance_count_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (mode_t'(in_mode) == MODE_TICK) ? S_WALK : S_QRY;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_QRY;
        end
      end
      S_QRY:  state_nxt = S_DATA;
      S_DATA: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = req_addr;
    wr_en    = 1'b0;
    wr_addr  = ra_r;
    clr_all  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_WALK: begin
        rd_en   = issue;
        rd_addr = SLOT_W'(walk_idx_r);
        wr_en   = rv_r;
      end
      S_QRY:  rd_en = 1'b1;
      S_DATA: begin
        out_load = out_free;
        wr_en    = out_free && slot_ok && wr_mode;
        wr_addr  = req_addr;
        clr_all  = out_free && (mode_r == MODE_CLEAR);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      instance_count_r <= '0;
      out_valid_r      <= 1'b0;
      rv_r             <= 1'b0;
      walk_idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        instance_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      rv_r <= issue;
      if (accept) begin
        walk_idx_r <= '0;
      end else if (issue) begin
        walk_idx_r <= walk_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode_t'(in_mode);
      req_r    <= in_instance_req;
      period_r <= in_frame_period;
      pc_r     <= in_pose_count;
      pb_r     <= in_pose_base;
      tb_r     <= in_transform_base;
      mc_r     <= in_mesh_count;
    end
    if (issue) begin
      ra_r <= SLOT_W'(walk_idx_r);
    end
    if (out_load) begin
      if (slot_ok) begin
        out_paused_r     <= (upd_rec.cd == CD_IDLE);
        out_deact_r      <= (upd_rec.cd == CD_IDLE) && !upd_rec.has_pose;
        out_pose_id_r    <= upd_rec.cur;
        out_pose_index_r <= upd_rec.root;
        out_xf_r         <= upd_rec.xf;
      end else begin
        out_paused_r     <= 1'b1;
        out_deact_r      <= 1'b1;
        out_pose_id_r    <= '0;
        out_pose_index_r <= '0;
        out_xf_r         <= '0;
      end
    end
  end

  always_comb begin
    upd_req.walk           = (state_r == S_WALK);
    upd_req.mode           = mode_r;
    upd_req.frame_period   = period_r;
    upd_req.pose_count     = pc_r;
    upd_req.pose_base      = pb_r;
    upd_req.transform_base = tb_r;
    upd_req.mesh_count     = mc_r;
  end

  aps_rec_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (upd_rec),
    .clr_all (clr_all)
  );

  aps_slot_upd u_upd (
    .req_i (upd_req),
    .rec_i (rd_rec),
    .rec_o (upd_rec)
  );

  assign out_valid           = out_valid_r;
  assign out_paused          = out_paused_r;
  assign out_deactivated     = out_deact_r;
  assign out_pose_id         = out_pose_id_r;
  assign out_pose_index      = out_pose_index_r;
  assign out_transform_index = out_xf_r;

  // a taken word always starts work
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("word accepted but sequencer stayed idle");

  // table writes come only from the walk or the result step
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_WALK || state_r == S_DATA))
    else $error("table write outside walk or result step");

  // walk write-back stays inside the walked range
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rv_r) |-> CNT_W'(ra_r) < n_lim)
    else $error("walk wrote a slot beyond instance_count");

  // a result appears only out of the result step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DATA)
    else $error("result raised outside result step");

endmodule

// ===== hdl/aps_rec_ram.sv =====
module aps_rec_ram
  import aps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output rec_t              rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  rec_t              wr_data,
  input  logic              clr_all
);

  rec_t mem [MAX_INSTANCES];
  rec_t raw_r;
  logic [SLOT_W-1:0] rd_addr_r;
  // live: countdown/has_pose hold real values; pval: period written
  logic [MAX_INSTANCES-1:0] live_r;
  logic [MAX_INSTANCES-1:0] pval_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_r     <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      pval_r <= '0;
    end else if (clr_all) begin
      live_r <= '0;
    end else if (wr_en) begin
      live_r[wr_addr] <= 1'b1;
      pval_r[wr_addr] <= 1'b1;
    end
  end

  // slots not live read as idle with no pose; unwritten period reads zero
  always_comb begin
    rd_data = raw_r;
    if (!live_r[rd_addr_r]) begin
      rd_data.cd       = CD_IDLE;
      rd_data.has_pose = 1'b0;
    end
    if (!pval_r[rd_addr_r]) begin
      rd_data.period = '0;
    end
  end

endmodule

// ===== hdl/aps_slot_upd.sv =====
module aps_slot_upd
  import aps_pkg::*;
(
  input  upd_req_t req_i,
  input  rec_t     rec_i,
  output rec_t     rec_o
);

  logic [15:0] cd_dec;
  logic [7:0]  wrap_last;
  logic [15:0] wrap_prod;
  logic [7:0]  start_last;
  logic [15:0] start_prod;
  rec_t        adv;
  rec_t        start_rec;

  assign cd_dec     = rec_i.cd - 16'd1;
  assign wrap_last  = rec_i.poses - 8'd1;
  assign wrap_prod  = 16'(wrap_last) * 16'(rec_i.meshes);
  assign start_last = req_i.pose_count - 8'd1;
  assign start_prod = 16'(start_last) * 16'(req_i.mesh_count);

  // one frame of a slot
  always_comb begin
    adv = rec_i;
    if (rec_i.cd != CD_IDLE) begin
      if (cd_dec != CD_IDLE) begin
        adv.cd = cd_dec;
      end else begin
        adv.cd = {1'b0, rec_i.period};
        if (rec_i.cur == 8'd0) begin
          adv.cur  = wrap_last;
          adv.root = rec_i.root + {9'd0, wrap_last};
          adv.xf   = rec_i.xf + {4'd0, wrap_prod};
        end else begin
          adv.cur  = rec_i.cur - 8'd1;
          adv.root = rec_i.root - 17'd1;
          adv.xf   = rec_i.xf - {12'd0, rec_i.meshes};
        end
      end
    end
  end

  always_comb begin
    start_rec.cd       = {1'b0, req_i.frame_period};
    start_rec.period   = req_i.frame_period;
    start_rec.poses    = req_i.pose_count;
    start_rec.cur      = start_last;
    start_rec.root     = {1'b0, req_i.pose_base} + {9'd0, start_last};
    start_rec.xf       = {4'd0, req_i.transform_base} + {4'd0, start_prod};
    start_rec.meshes   = req_i.mesh_count;
    start_rec.has_pose = 1'b1;
  end

  always_comb begin
    rec_o = rec_i;
    if (req_i.walk) begin
      rec_o = adv;
    end else begin
      unique case (req_i.mode)
        MODE_CLEAR: begin
          rec_o.cd       = CD_IDLE;
          rec_o.has_pose = 1'b0;
        end
        MODE_START:   rec_o = start_rec;
        MODE_PAUSE:   rec_o.cd = CD_IDLE;
        MODE_UNPAUSE: rec_o.cd = {1'b0, rec_i.period};
        MODE_DEACT: begin
          rec_o.cd       = CD_IDLE;
          rec_o.has_pose = 1'b0;
        end
        default:      rec_o = rec_i;
      endcase
    end
  end

endmodule
